// ===== sv/frame_to_page_packer_defines.svh =====
// assertion macros for the frame to page packer
// used by frame_to_page_packer.sv; expects clk and arst_n in scope
`ifndef FRAME_TO_PAGE_PACKER_DEFINES_SVH
`define FRAME_TO_PAGE_PACKER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define FTPP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ftpp check failed: same cycle");

// next-cycle implication, quiet during reset
`define FTPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ftpp check failed: next cycle");

`endif

// ===== sv/ftpp_pkg.sv =====
// types and constants of the frame to page packer
// no dependencies
package ftpp_pkg;

	localparam int POOL_DEPTH_DEF  = 64;
	localparam int MAX_FRAME_BYTES = 2048;

	localparam int PB_W    = 17;
	localparam int PP_W    = 7;
	localparam int LEN_W   = 12;
	localparam int IDX_W   = 6;
	localparam int OFS_W   = 16;
	localparam int SEQ_W   = 32;
	localparam int DISP_W  = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [PB_W-1:0] PAGE_BYTES_RST = 17'd4096;
	localparam logic [PP_W-1:0] POOL_PAGES_RST = 7'd64;

	// command codes
	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES = 1'b1;

	// disposition codes
	localparam logic [DISP_W-1:0] DISP_FREE             = 3'd0;
	localparam logic [DISP_W-1:0] DISP_FLUSH            = 3'd1;
	localparam logic [DISP_W-1:0] DISP_PAYLOAD          = 3'd2;
	localparam logic [DISP_W-1:0] DISP_PAYLOAD_RUNDOWN  = 3'd3;
	localparam logic [DISP_W-1:0] DISP_RUNDOWN          = 3'd4;

	typedef struct packed {
		logic             command;
		logic [LEN_W-1:0] frame_bytes;
		logic             start_of_frame;
		logic             end_of_frame;
		logic             payload_by_dma;
		logic [IDX_W-1:0] free_index;
	} item_t;

	typedef struct packed {
		logic [DISP_W-1:0] disposition;
		logic [IDX_W-1:0]  page_index;
		logic [OFS_W-1:0]  write_offset;
		logic              page_done;
		logic [SEQ_W-1:0]  page_sequence;
		logic              page_first;
		logic              page_last;
		logic              page_error;
		logic              split_valid;
		logic [IDX_W-1:0]  next_page_index;
		logic [LEN_W-1:0]  spill_bytes;
	} result_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} grab_t;

endpackage

// ===== sv/frame_to_page_packer.sv =====
// frame to page packer: frame descriptors in, page placement results out
// depends on ftpp_pkg and frame_to_page_packer_defines.svh
//
// Usage
//   Input channel (in_valid/in_ready) carries one frame descriptor or one
//   page free command per transfer. Output channel (out_valid/out_ready)
//   returns exactly one result per input transfer, in order.
//   An accepted item sits in an input register, is resolved against the
//   page state by combinational logic (fill update and two lowest-free-page
//   priority encoders over the pool map) and lands in the result register.
//   Throughput is one item per cycle while the receiver does not stall; the
//   state is read and updated only where an item leaves the input register,
//   so back to back items see each other's effects.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready drops only when both are occupied.
//   Reset (arst_n low) empties both registers, marks every pool page free,
//   drops the active page, clears the marks and counters and loads
//   page_bytes 4096 and pool_pages 64. Registers are written through cfg_we/cfg_index/cfg_data
//   with no wait; the user writes them only while no item is in flight, unenforced by the block.
`include "frame_to_page_packer_defines.svh"

module frame_to_page_packer #(
	parameter int POOL_DEPTH = ftpp_pkg::POOL_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ftpp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ftpp_pkg::PB_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         command,
	input  logic [ftpp_pkg::LEN_W-1:0]   frame_bytes,
	input  logic                         start_of_frame,
	input  logic                         end_of_frame,
	input  logic                         payload_by_dma,
	input  logic [ftpp_pkg::IDX_W-1:0]   free_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ftpp_pkg::DISP_W-1:0]  disposition,
	output logic [ftpp_pkg::IDX_W-1:0]   page_index,
	output logic [ftpp_pkg::OFS_W-1:0]   write_offset,
	output logic                         page_done,
	output logic [ftpp_pkg::SEQ_W-1:0]   page_sequence,
	output logic                         page_first,
	output logic                         page_last,
	output logic                         page_error,
	output logic                         split_valid,
	output logic [ftpp_pkg::IDX_W-1:0]   next_page_index,
	output logic [ftpp_pkg::LEN_W-1:0]   spill_bytes
);
	import ftpp_pkg::*;

	localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int TOT_W = PB_W + 1;

	// lowest set bit of a pool map
	function automatic grab_t lowest_set(input logic [POOL_DEPTH-1:0] v);
		grab_t g;
		g = '0;
		for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
			if (v[i]) begin
				g.found = 1'b1;
				g.idx   = IDX_W'(i);
			end
		end
		return g;
	endfunction

	// configuration
	logic [PB_W-1:0] page_bytes_q;
	logic [PP_W-1:0] pool_pages_q;

	// page state
	logic [POOL_DEPTH-1:0] free_map_q;
	logic                  active_valid_q;
	logic [IDX_W-1:0]      active_page_q;
	logic [PB_W-1:0]       active_fill_q;
	logic                  active_first_q;
	logic                  active_last_q;
	logic [SEQ_W-1:0]      sequence_count_q;
	logic                  error_mark_q;

	// pipeline
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;

	// next state and result
	logic [POOL_DEPTH-1:0] pool_mask;
	logic [POOL_DEPTH-1:0] fm;
	logic                  av;
	logic [IDX_W-1:0]      ap;
	logic [PB_W-1:0]       af;
	logic                  afirst;
	logic                  alast;
	logic [SEQ_W-1:0]      sc;
	logic                  em;
	result_t               r;
	logic [LEN_W-1:0]      len;
	logic [TOT_W-1:0]      total;
	logic [TOT_W-1:0]      over;
	logic [LEN_W-1:0]      spill;
	logic                  done;
	logic                  ok;
	grab_t                 g1;
	grab_t                 g2;
	logic [DISP_W-1:0]     drop_disp;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_comb begin
		for (int i = 0; i < POOL_DEPTH; i++) begin
			pool_mask[i] = (PP_W'(i) < pool_pages_q);
		end
	end

	always_comb begin
		fm     = free_map_q;
		av     = active_valid_q;
		ap     = active_page_q;
		af     = active_fill_q;
		afirst = active_first_q;
		alast  = active_last_q;
		sc     = sequence_count_q;
		em     = error_mark_q;
		r      = '0;
		len    = item_s1.frame_bytes;
		total  = '0;
		over   = '0;
		spill  = '0;
		done   = 1'b0;
		ok     = 1'b1;
		g1     = '0;
		g2     = '0;
		drop_disp = item_s1.payload_by_dma ? DISP_FLUSH : DISP_FREE;
		unique case (item_s1.command)
			CMD_FREE: begin
				if ((PP_W'(item_s1.free_index) < PP_W'(POOL_DEPTH)) &&
				    !(av && (ap == item_s1.free_index))) begin
					fm[item_s1.free_index[PW-1:0]] = 1'b1;
				end
			end
			CMD_FRAME: begin
				if ((13'(item_s1.frame_bytes)) > 13'(MAX_FRAME_BYTES)) begin
					len = LEN_W'(MAX_FRAME_BYTES);
				end
				if (em && !item_s1.start_of_frame) begin
					// discard until the next start of frame
					if (av) begin
						fm[ap[PW-1:0]] = 1'b1;
						av = 1'b0;
					end
					r.disposition = drop_disp;
				end else begin
					if (!av) begin
						g1 = lowest_set(fm & pool_mask);
						if (!g1.found) begin
							sc = '0;
							em = 1'b1;
							ok = 1'b0;
							r.disposition = drop_disp;
						end else begin
							fm[g1.idx[PW-1:0]] = 1'b0;
							av     = 1'b1;
							ap     = g1.idx;
							af     = '0;
							afirst = 1'b0;
							alast  = 1'b0;
						end
					end
					if (ok) begin
						r.page_index   = ap;
						r.write_offset = af[OFS_W-1:0];
						if (item_s1.start_of_frame) begin
							sc     = '0;
							afirst = 1'b1;
						end
						if (item_s1.end_of_frame) begin
							alast = 1'b1;
						end
						total = TOT_W'(af) + TOT_W'(len);
						if (total > TOT_W'(page_bytes_q)) begin
							over  = total - TOT_W'(page_bytes_q);
							spill = (over > TOT_W'(len)) ? len : over[LEN_W-1:0];
							g2 = lowest_set(fm & pool_mask);
							if (!g2.found) begin
								// no page for the spill: drop the active one too
								sc = '0;
								em = 1'b1;
								fm[ap[PW-1:0]] = 1'b1;
								av = 1'b0;
								r = '0;
								r.disposition = drop_disp;
								ok = 1'b0;
							end else begin
								fm[g2.idx[PW-1:0]] = 1'b0;
								done              = 1'b1;
								r.split_valid     = 1'b1;
								r.next_page_index = g2.idx;
								r.spill_bytes     = spill;
								r.page_done       = 1'b1;
								r.page_sequence   = sc;
								r.page_first      = afirst;
								r.page_last       = alast;
								r.page_error      = em;
								sc = sc + 1'b1;
								em = 1'b0;
								if (item_s1.end_of_frame) begin
									sc = '0;
								end
								ap     = g2.idx;
								af     = PB_W'(spill);
								afirst = 1'b0;
								alast  = 1'b0;
							end
						end else begin
							af   = total[PB_W-1:0];
							done = (total >= TOT_W'(page_bytes_q)) ||
							       item_s1.end_of_frame;
							if (done) begin
								r.page_done     = 1'b1;
								r.page_sequence = sc;
								r.page_first    = afirst;
								r.page_last     = alast;
								r.page_error    = em;
								sc = sc + 1'b1;
								em = 1'b0;
								if (item_s1.end_of_frame) begin
									sc = '0;
								end
								av = 1'b0;
							end
						end
						if (ok) begin
							if (item_s1.payload_by_dma) begin
								r.disposition = done ? DISP_PAYLOAD_RUNDOWN : DISP_PAYLOAD;
							end else begin
								r.disposition = done ? DISP_RUNDOWN : DISP_FREE;
							end
						end
					end
				end
			end
			default: begin
				r = '0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bytes_q <= PAGE_BYTES_RST;
			pool_pages_q <= POOL_PAGES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAGE_BYTES: page_bytes_q <= cfg_data;
				CFG_POOL_PAGES: pool_pages_q <= cfg_data[PP_W-1:0];
				default: ;
			endcase
		end
	end

	// page state, updated as an item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_map_q       <= '1;
			active_valid_q   <= 1'b0;
			active_page_q    <= '0;
			active_fill_q    <= '0;
			active_first_q   <= 1'b0;
			active_last_q    <= 1'b0;
			sequence_count_q <= '0;
			error_mark_q     <= 1'b0;
		end else if (adv) begin
			free_map_q       <= fm;
			active_valid_q   <= av;
			active_page_q    <= ap;
			active_fill_q    <= af;
			active_first_q   <= afirst;
			active_last_q    <= alast;
			sequence_count_q <= sc;
			error_mark_q     <= em;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.command        <= command;
			item_s1.frame_bytes    <= frame_bytes;
			item_s1.start_of_frame <= start_of_frame;
			item_s1.end_of_frame   <= end_of_frame;
			item_s1.payload_by_dma <= payload_by_dma;
			item_s1.free_index     <= free_index;
		end
		if (adv) begin
			res_s2 <= r;
		end
	end

	assign out_valid       = valid_s2;
	assign disposition     = res_s2.disposition;
	assign page_index      = res_s2.page_index;
	assign write_offset    = res_s2.write_offset;
	assign page_done       = res_s2.page_done;
	assign page_sequence   = res_s2.page_sequence;
	assign page_first      = res_s2.page_first;
	assign page_last       = res_s2.page_last;
	assign page_error      = res_s2.page_error;
	assign split_valid     = res_s2.split_valid;
	assign next_page_index = res_s2.next_page_index;
	assign spill_bytes     = res_s2.spill_bytes;

	// an open page is never in the free pool
	`FTPP_ASSERT_NOW(a_active_not_free, active_valid_q, !free_map_q[active_page_q[PW-1:0]])
	// a spilled frame always completes its page
	`FTPP_ASSERT_NOW(a_split_done, valid_s2 && res_s2.split_valid, res_s2.page_done)
	// results without a completed page carry no page marks
	`FTPP_ASSERT_NOW(a_undone_clean, valid_s2 && !res_s2.page_done,
		!res_s2.page_first && !res_s2.page_last && !res_s2.page_error && !res_s2.split_valid)
	// a held result stays put while the receiver stalls
	`FTPP_ASSERT_NEXT(a_stall_hold, valid_s2 && !out_ready, valid_s2 && $stable(res_s2))

endmodule

// ===== test/frame_to_page_packer_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for frame_to_page_packer: directed and random descriptors
// with a cycle-free placement predictor; depends on ftpp_pkg and the packer rtl
module frame_to_page_packer_tb;
	import ftpp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_SETTINGS = 9;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PAGE_BYTES;
	logic [PB_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = CMD_FRAME;
	logic [LEN_W-1:0] frame_bytes = '0;
	logic start_of_frame = 1'b0;
	logic end_of_frame = 1'b0;
	logic payload_by_dma = 1'b0;
	logic [IDX_W-1:0] free_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DISP_W-1:0] disposition;
	logic [IDX_W-1:0] page_index;
	logic [OFS_W-1:0] write_offset;
	logic page_done;
	logic [SEQ_W-1:0] page_sequence;
	logic page_first;
	logic page_last;
	logic page_error;
	logic split_valid;
	logic [IDX_W-1:0] next_page_index;
	logic [LEN_W-1:0] spill_bytes;

	// packer state as the checker sees it
	logic [63:0] pool_free;
	logic cur_valid;
	logic [IDX_W-1:0] cur_page;
	int unsigned cur_fill;
	logic cur_first;
	logic cur_last;
	logic [SEQ_W-1:0] seq_count;
	logic err_mark;
	int unsigned page_cap;
	int unsigned pool_limit;

	item_t descriptors[$];
	result_t predicted_placements[$];
	item_t offered;
	int send_gap = 0;
	bit in_burst = 1'b0;
	int take_stall = 0;
	bit out_burst = 1'b0;
	int hold_left = 0;
	bit held_off = 1'b0;
	int n_results = 0;
	int n_errors = 0;
	int idle_cycles = 0;

	int unsigned cap_list[N_SETTINGS] = '{4096, 1, 65536, 64, 512, 2048, 1, 100, 4096};
	int unsigned pool_list[N_SETTINGS] = '{64, 1, 64, 4, 16, 2, 64, 64, 8};

	frame_to_page_packer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.frame_bytes(frame_bytes),
		.start_of_frame(start_of_frame),
		.end_of_frame(end_of_frame),
		.payload_by_dma(payload_by_dma),
		.free_index(free_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.disposition(disposition),
		.page_index(page_index),
		.write_offset(write_offset),
		.page_done(page_done),
		.page_sequence(page_sequence),
		.page_first(page_first),
		.page_last(page_last),
		.page_error(page_error),
		.split_valid(split_valid),
		.next_page_index(next_page_index),
		.spill_bytes(spill_bytes)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// lowest free page under the pool limit; a miss restarts the sequence and marks an error
	function automatic grab_t take_page();
		grab_t g;
		int unsigned lim;
		logic [63:0] avail;
		int i;
		g = '0;
		lim = (pool_limit < POOL_DEPTH_DEF) ? pool_limit : POOL_DEPTH_DEF;
		avail = (lim >= 64) ? pool_free : pool_free & ((64'd1 << lim) - 64'd1);
		if (avail == '0) begin
			seq_count = '0;
			err_mark = 1'b1;
			return g;
		end
		for (i = 63; i >= 0; i--)
			if (avail[i])
				g.idx = i[IDX_W-1:0];
		g.found = 1'b1;
		pool_free[g.idx] = 1'b0;
		return g;
	endfunction

	function automatic void return_active();
		if (cur_valid) begin
			pool_free[cur_page] = 1'b1;
			cur_valid = 1'b0;
		end
	endfunction

	function automatic result_t seal_page(result_t r, logic eof);
		r.page_done = 1'b1;
		r.page_sequence = seq_count;
		r.page_first = cur_first;
		r.page_last = cur_last;
		r.page_error = err_mark;
		seq_count = seq_count + 1;
		err_mark = 1'b0;
		if (eof)
			seq_count = '0;
		return r;
	endfunction

	// placement of one accepted descriptor, updating the page state
	function automatic result_t place_item(item_t it);
		result_t r;
		int unsigned len, total, spill, offset;
		logic [IDX_W-1:0] page;
		logic done;
		grab_t g;
		logic [DISP_W-1:0] drop_disp;
		r = '0;
		drop_disp = it.payload_by_dma ? DISP_FLUSH : DISP_FREE;
		if (it.command == CMD_FREE) begin
			if (!(cur_valid && cur_page == it.free_index))
				pool_free[it.free_index] = 1'b1;
			r.disposition = DISP_FREE;
			return r;
		end
		len = it.frame_bytes;
		if (len > MAX_FRAME_BYTES)
			len = MAX_FRAME_BYTES;
		// discarding until the next start of frame
		if (err_mark && !it.start_of_frame) begin
			return_active();
			r.disposition = drop_disp;
			return r;
		end
		if (!cur_valid) begin
			g = take_page();
			if (!g.found) begin
				r.disposition = drop_disp;
				return r;
			end
			cur_valid = 1'b1;
			cur_page = g.idx;
			cur_fill = 0;
			cur_first = 1'b0;
			cur_last = 1'b0;
		end
		page = cur_page;
		offset = cur_fill;
		if (it.start_of_frame) begin
			seq_count = '0;
			cur_first = 1'b1;
		end
		if (it.end_of_frame)
			cur_last = 1'b1;
		total = cur_fill + len;
		if (total > page_cap) begin
			spill = total - page_cap;
			if (spill > len)
				spill = len;
			g = take_page();
			if (!g.found) begin
				return_active();
				r.disposition = drop_disp;
				return r;
			end
			r.split_valid = 1'b1;
			r.next_page_index = g.idx;
			r.spill_bytes = spill[LEN_W-1:0];
			done = 1'b1;
			r = seal_page(r, it.end_of_frame);
			cur_page = g.idx;
			cur_fill = spill;
			cur_first = 1'b0;
			cur_last = 1'b0;
		end else begin
			cur_fill = total;
			done = (total >= page_cap) || it.end_of_frame;
			if (done) begin
				r = seal_page(r, it.end_of_frame);
				cur_valid = 1'b0;
			end
		end
		r.page_index = page;
		r.write_offset = offset[OFS_W-1:0];
		if (it.payload_by_dma)
			r.disposition = done ? DISP_PAYLOAD_RUNDOWN : DISP_PAYLOAD;
		else
			r.disposition = done ? DISP_RUNDOWN : DISP_FREE;
		return r;
	endfunction

	task automatic push_frame(logic sof, logic eof, logic dma, logic [LEN_W-1:0] len);
		item_t it;
		it.command = CMD_FRAME;
		it.frame_bytes = len;
		it.start_of_frame = sof;
		it.end_of_frame = eof;
		it.payload_by_dma = dma;
		it.free_index = IDX_W'($urandom_range(0, 63));
		descriptors.push_back(it);
	endtask

	task automatic push_free(int unsigned idx);
		item_t it;
		it.command = CMD_FREE;
		it.frame_bytes = LEN_W'($urandom_range(0, 4095));
		it.start_of_frame = 1'($urandom_range(0, 1));
		it.end_of_frame = 1'($urandom_range(0, 1));
		it.payload_by_dma = 1'($urandom_range(0, 1));
		it.free_index = idx[IDX_W-1:0];
		descriptors.push_back(it);
	endtask

	// mostly lengths that fit a page, with empty, maximal and over-long frames mixed in
	function automatic logic [LEN_W-1:0] pick_len();
		int unsigned hi;
		hi = (page_cap > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : page_cap;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return LEN_W'($urandom_range(MAX_FRAME_BYTES + 1, 4095));
			2: return LEN_W'(MAX_FRAME_BYTES);
			default: return LEN_W'($urandom_range(1, hi));
		endcase
	endfunction

	task automatic queue_traffic(int count);
		int added, nfr, k, kind;
		int unsigned lim;
		lim = (pool_limit > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF : pool_limit;
		added = 0;
		while (added < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				push_free(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, lim - 1));
				added++;
			end else if (kind < 40) begin
				push_frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 4095)));
				added++;
			end else begin
				// a whole frame sequence: start mark first, end mark last
				nfr = $urandom_range(1, 4);
				for (k = 0; k < nfr; k++)
					push_frame(k == 0, k == nfr - 1, 1'($urandom_range(0, 1)), pick_len());
				added += nfr;
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PB_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(int unsigned cap, int unsigned pool);
		write_reg(CFG_PAGE_BYTES, cap[PB_W-1:0]);
		write_reg(CFG_POOL_PAGES, {{(PB_W - PP_W){1'b0}}, pool[PP_W-1:0]});
		page_cap = cap;
		pool_limit = pool;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (descriptors.size() != 0 || in_valid || predicted_placements.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			n_errors++;
		end
	endtask

	// sender: one gap draw per transfer, payload held until accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted_placements.push_back(place_item(offered));
				send_gap = in_burst ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 15) == 0)
					in_burst = !in_burst;
			end
			if (!(in_valid && !in_ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (descriptors.size() > 0) begin
					offered = descriptors.pop_front();
					in_valid <= 1'b1;
					command <= offered.command;
					frame_bytes <= offered.frame_bytes;
					start_of_frame <= offered.start_of_frame;
					end_of_frame <= offered.end_of_frame;
					payload_by_dma <= offered.payload_by_dma;
					free_index <= offered.free_index;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each transfer, stalls at random and once for a long stretch
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (predicted_placements.size() == 0) begin
					$display("%0t: unexpected result, expected none, got disposition %0d page %0d",
						$time, disposition, page_index);
					n_errors++;
				end else begin
					want = predicted_placements.pop_front();
					check_field("disposition", want.disposition, disposition);
					check_field("page_index", want.page_index, page_index);
					check_field("write_offset", want.write_offset, write_offset);
					check_field("page_done", want.page_done, page_done);
					check_field("page_sequence", want.page_sequence, page_sequence);
					check_field("page_first", want.page_first, page_first);
					check_field("page_last", want.page_last, page_last);
					check_field("page_error", want.page_error, page_error);
					check_field("split_valid", want.split_valid, split_valid);
					check_field("next_page_index", want.next_page_index, next_page_index);
					check_field("spill_bytes", want.spill_bytes, spill_bytes);
				end
				n_results++;
				take_stall = out_burst ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 15) == 0)
					out_burst = !out_burst;
			end
			// long back-pressure mid-run so the input side fills and stalls
			if (!held_off && n_results >= 350) begin
				held_off = 1'b1;
				hold_left = 120;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (take_stall > 0) begin
				take_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int s;
		pool_free = '1;
		cur_valid = 1'b0;
		cur_page = '0;
		cur_fill = 0;
		cur_first = 1'b0;
		cur_last = 1'b0;
		seq_count = '0;
		err_mark = 1'b0;
		page_cap = PAGE_BYTES_RST;
		pool_limit = POOL_PAGES_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: empty frame, clamped long frame, frees of active and free pages, a split
		push_frame(1'b1, 1'b1, 1'b1, 12'd0);
		push_frame(1'b1, 1'b0, 1'b0, 12'd2048);
		push_frame(1'b0, 1'b0, 1'b1, 12'd4095);
		push_frame(1'b1, 1'b0, 1'b0, 12'd2000);
		push_frame(1'b0, 1'b0, 1'b1, 12'd2000);
		push_free(2);
		push_free(0);
		push_free(0);
		push_frame(1'b0, 1'b1, 1'b1, 12'd2000);
		push_free(1);
		push_free(63);
		wait_drained();

		// shrunk page under a part-filled one, pool exhaustion, discards, failed spill
		apply_setting(64, 2);
		push_frame(1'b0, 1'b0, 1'b1, 12'd10);
		push_frame(1'b1, 1'b1, 1'b0, 12'd20);
		push_frame(1'b1, 1'b0, 1'b0, 12'd5);
		push_frame(1'b0, 1'b0, 1'b1, 12'd9);
		push_free(0);
		push_frame(1'b0, 1'b1, 1'b0, 12'd7);
		push_frame(1'b1, 1'b0, 1'b1, 12'd30);
		push_frame(1'b0, 1'b0, 1'b0, 12'd50);
		push_free(1);
		push_frame(1'b1, 1'b1, 1'b1, 12'd40);
		wait_drained();

		for (s = 0; s < N_SETTINGS; s++) begin
			apply_setting(cap_list[s], pool_list[s]);
			queue_traffic(130);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (n_errors == 0 && predicted_placements.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
